>>> rtl/assert_macros.svh
// assertion helpers used by the top level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/mscs_pkg.sv
package mscs_pkg;

  // widths
  localparam int PcWidth     = 16;
  localparam int LenWidth    = 16;
  localparam int RegCount    = 32;
  localparam int RegAddrW    = $clog2(RegCount);
  localparam int DataWidth   = 32;

  // fixed register numbers: the zero register and the syscall registers v0 and a0
  localparam logic [RegAddrW-1:0] ZeroReg = RegAddrW'(0);
  localparam logic [RegAddrW-1:0] V0Reg   = RegAddrW'(2);
  localparam logic [RegAddrW-1:0] A0Reg   = RegAddrW'(4);

  // instruction encodings
  localparam logic [31:0] RTypeMask   = 32'hFC0007FF;
  localparam logic [31:0] FunctAdd    = 32'h00000020;
  localparam logic [31:0] FunctSub    = 32'h00000022;
  localparam logic [31:0] FunctSlt    = 32'h0000002A;
  localparam logic [31:0] FunctMul    = 32'h70000002;
  localparam logic [31:0] OpcodeMask  = 32'hFC000000;
  localparam logic [31:0] OpcodeBeq   = 32'h10000000;
  localparam logic [31:0] OpcodeBne   = 32'h14000000;
  localparam logic [31:0] OpcodeAddi  = 32'h20000000;
  localparam logic [31:0] OpcodeOri   = 32'h34000000;
  localparam logic [31:0] LuiMask     = 32'hFFE00000;
  localparam logic [31:0] OpcodeLui   = 32'h3C000000;
  localparam logic [31:0] SyscallWord = 32'h0000000C;

  // syscall service numbers in v0
  localparam logic [31:0] SvcPrintInt  = 32'd1;
  localparam logic [31:0] SvcExit      = 32'd10;
  localparam logic [31:0] SvcPrintChar = 32'd11;

  typedef enum logic [3:0] {
    OpNone,
    OpAdd,
    OpSub,
    OpSlt,
    OpMul,
    OpBeq,
    OpBne,
    OpAddi,
    OpOri,
    OpLui,
    OpSyscall
  } op_e;

  typedef enum logic [2:0] {
    ScNone      = 3'd0,
    ScPrintInt  = 3'd1,
    ScPrintChar = 3'd2,
    ScExit      = 3'd3,
    ScUnknown   = 3'd4
  } sc_act_e;

  // execute result handed from the alu to the control
  typedef struct packed {
    logic                wr;
    logic [RegAddrW-1:0] dreg;
    logic [DataWidth-1:0] dval;
    logic                taken;
    sc_act_e             sc_act;
    logic [DataWidth-1:0] sc_val;
    logic                stop_now;
  } exec_res_t;

  // priority decode of one instruction word
  function automatic op_e decode_op(input logic [31:0] w);
    op_e op;
    op = OpNone;
    if ((w & RTypeMask) == FunctAdd) begin
      op = OpAdd;
    end else if ((w & RTypeMask) == FunctSub) begin
      op = OpSub;
    end else if ((w & RTypeMask) == FunctSlt) begin
      op = OpSlt;
    end else if ((w & RTypeMask) == FunctMul) begin
      op = OpMul;
    end else if ((w & OpcodeMask) == OpcodeBeq) begin
      op = OpBeq;
    end else if ((w & OpcodeMask) == OpcodeBne) begin
      op = OpBne;
    end else if ((w & OpcodeMask) == OpcodeAddi) begin
      op = OpAddi;
    end else if ((w & OpcodeMask) == OpcodeOri) begin
      op = OpOri;
    end else if ((w & LuiMask) == OpcodeLui) begin
      op = OpLui;
    end else if (w == SyscallWord) begin
      op = OpSyscall;
    end
    return op;
  endfunction

endpackage

>>> rtl/mips_subset_core_step_top.sv
// an accepted request waits in the execute stage register; its result then goes to the output register
// throughput: one instruction per cycle while the output is not stalled, limited by the register file read
//   in the accept cycle and the execute and write back when the execute stage advances
// reset: registers read as zero, pc zero, run not halted, program length zero
// a halt is cleared only by reset
module mips_subset_core_step_top
  import mscs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LenWidth-1:0]  cfg_program_length_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          instruction_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          next_pc_o,
  output logic                 reg_written_o,
  output logic [4:0]           dest_reg_o,
  output logic [31:0]          dest_value_o,
  output logic                 branch_taken_o,
  output logic [2:0]           syscall_action_o,
  output logic [31:0]          syscall_value_o,
  output logic                 stopped_o
);

`include "assert_macros.svh"

  logic                 accept;
  logic                 adv;
  logic                 is_sys;
  logic [RegAddrW-1:0]  raddr_a, raddr_b;
  logic                 rf_we;
  logic [DataWidth-1:0] op_a, op_b;
  exec_res_t            res;

  logic                 ex_vld_q;
  logic [31:0]          ex_instr_q;
  logic [PcWidth-1:0]   pc_q, pc_d;
  logic                 halted_q, halted_d;
  logic [LenWidth-1:0]  len_q;
  logic                 run;
  logic                 wr_ok;
  logic [DataWidth-1:0] br_off;
  logic [PcWidth-1:0]   npc;

  logic                 out_vld_q;
  logic [PcWidth-1:0]   out_pc_q;
  logic                 out_wr_q, out_taken_q, out_stopped_q;
  logic [RegAddrW-1:0]  out_dreg_q;
  logic [DataWidth-1:0] out_dval_q, out_sc_val_q;
  sc_act_e              out_sc_act_q;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign adv         = ex_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = ex_vld_q && !adv;
  assign accept      = in_valid_i && !in_stall_o;

  // syscall reads v0 and a0 in place of rs and rt
  assign is_sys  = (decode_op(instruction_word_i) == OpSyscall);
  assign raddr_a = is_sys ? V0Reg : instruction_word_i[25:21];
  assign raddr_b = is_sys ? A0Reg : instruction_word_i[20:16];

  mscs_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .we_i      (rf_we),
    .waddr_i   (res.dreg),
    .wdata_i   (res.dval),
    .rdata_a_o (op_a),
    .rdata_b_o (op_b)
  );

  mscs_alu u_alu (
    .instr_i (ex_instr_q),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .res_o   (res)
  );

  // execute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
    end else if (accept) begin
      ex_vld_q <= 1'b1;
    end else if (adv) begin
      ex_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_instr_q <= instruction_word_i;
    end
  end

  // pc and halt update
  assign run    = !halted_q && (pc_q < PcWidth'(len_q));
  assign wr_ok  = run && res.wr && (res.dreg != ZeroReg);
  assign rf_we  = adv && wr_ok;
  assign br_off = {{(DataWidth-16){ex_instr_q[15]}}, ex_instr_q[15:0]};
  assign npc    = res.taken ? (pc_q + br_off[PcWidth-1:0]) : (pc_q + PcWidth'(1));

  always_comb begin
    pc_d     = pc_q;
    halted_d = halted_q;
    if (!halted_q) begin
      if (!run) begin
        halted_d = 1'b1;
      end else if (res.stop_now) begin
        halted_d = 1'b1;
      end else begin
        pc_d     = npc;
        halted_d = (npc >= PcWidth'(len_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halted_q <= 1'b0;
    end else if (adv) begin
      pc_q     <= pc_d;
      halted_q <= halted_d;
    end
  end

  // program length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_program_length_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pc_q      <= pc_d;
      out_wr_q      <= wr_ok;
      out_dreg_q    <= wr_ok ? res.dreg : ZeroReg;
      out_dval_q    <= wr_ok ? res.dval : '0;
      out_taken_q   <= run && res.taken;
      out_sc_act_q  <= run ? res.sc_act : ScNone;
      out_sc_val_q  <= run ? res.sc_val : '0;
      out_stopped_q <= halted_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign next_pc_o        = 16'(out_pc_q);
  assign reg_written_o    = out_wr_q;
  assign dest_reg_o       = out_dreg_q;
  assign dest_value_o     = out_dval_q;
  assign branch_taken_o   = out_taken_q;
  assign syscall_action_o = out_sc_act_q;
  assign syscall_value_o  = out_sc_val_q;
  assign stopped_o        = out_stopped_q;

  // checks
  `ASSERT_NEVER(a_no_zero_write, clk_i, rst_ni, rf_we && (res.dreg == ZeroReg), "write to reg zero")
  `ASSERT_CLK(a_halt_sticks, clk_i, rst_ni, halted_q |=> halted_q, "halt cleared without reset")
  `ASSERT_CLK(a_halted_idle, clk_i, rst_ni, (adv && halted_q) |=> (out_stopped_q && !out_wr_q && !out_taken_q), "result after halt not idle")
  `ASSERT_CLK(a_pc_held_halted, clk_i, rst_ni, halted_q |=> $stable(pc_q), "pc moved after halt")

endmodule

>>> rtl/mscs_regfile.sv
module mscs_regfile
  import mscs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [RegAddrW-1:0]  raddr_a_i,
  input  logic [RegAddrW-1:0]  raddr_b_i,
  input  logic                 we_i,
  input  logic [RegAddrW-1:0]  waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  output logic [DataWidth-1:0] rdata_a_o,
  output logic [DataWidth-1:0] rdata_b_o
);

  logic [DataWidth-1:0] mem_q [RegCount];
  logic [RegCount-1:0]  vld_q;
  logic [DataWidth-1:0] mem_a_q, mem_b_q;
  logic [DataWidth-1:0] byp_data_q;
  logic                 byp_a_q, byp_b_q;
  logic                 hit_a_q, hit_b_q;

  // storage array, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      mem_a_q <= mem_q[raddr_a_i];
      mem_b_q <= mem_q[raddr_b_i];
    end
  end

  // per entry written flags, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // bypass a write that lands on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_a_q <= we_i && (waddr_i == raddr_a_i);
      byp_b_q <= we_i && (waddr_i == raddr_b_i);
      hit_a_q <= vld_q[raddr_a_i];
      hit_b_q <= vld_q[raddr_b_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_data_q <= wdata_i;
    end
  end

  assign rdata_a_o = byp_a_q ? byp_data_q : (hit_a_q ? mem_a_q : '0);
  assign rdata_b_o = byp_b_q ? byp_data_q : (hit_b_q ? mem_b_q : '0);

endmodule

>>> rtl/mscs_alu.sv
module mscs_alu
  import mscs_pkg::*;
(
  input  logic [31:0]          instr_i,
  input  logic [DataWidth-1:0] op_a_i,
  input  logic [DataWidth-1:0] op_b_i,
  output exec_res_t            res_o
);

  op_e                  op;
  logic [15:0]          imm;
  logic [DataWidth-1:0] simm;
  logic [DataWidth-1:0] zimm;
  logic [63:0]          prod;
  logic [RegAddrW-1:0]  rt, rd;

  // instruction fields
  assign op   = decode_op(instr_i);
  assign imm  = instr_i[15:0];
  assign simm = {{(DataWidth-16){imm[15]}}, imm};
  assign zimm = {{(DataWidth-16){1'b0}}, imm};
  assign rt   = instr_i[20:16];
  assign rd   = instr_i[15:11];
  assign prod = 64'(op_a_i) * 64'(op_b_i);

  // operation select
  always_comb begin
    res_o          = '0;
    res_o.sc_act   = ScNone;
    unique case (op)
      OpAdd: begin
        res_o.wr = 1'b1; res_o.dreg = rd; res_o.dval = op_a_i + op_b_i;
      end
      OpSub: begin
        res_o.wr = 1'b1; res_o.dreg = rd; res_o.dval = op_a_i - op_b_i;
      end
      OpSlt: begin
        res_o.wr   = 1'b1;
        res_o.dreg = rd;
        res_o.dval = DataWidth'($signed(op_a_i) < $signed(op_b_i));
      end
      OpMul: begin
        res_o.wr = 1'b1; res_o.dreg = rd; res_o.dval = prod[DataWidth-1:0];
      end
      OpBeq: res_o.taken = (op_a_i == op_b_i);
      OpBne: res_o.taken = (op_a_i != op_b_i);
      OpAddi: begin
        res_o.wr = 1'b1; res_o.dreg = rt; res_o.dval = op_a_i + simm;
      end
      OpOri: begin
        res_o.wr = 1'b1; res_o.dreg = rt; res_o.dval = op_a_i | zimm;
      end
      OpLui: begin
        res_o.wr = 1'b1; res_o.dreg = rt; res_o.dval = {imm, 16'h0000};
      end
      OpSyscall: begin
        // operand a holds v0, operand b holds a0
        if (op_a_i == SvcPrintInt) begin
          res_o.sc_act = ScPrintInt;
          res_o.sc_val = op_b_i;
        end else if (op_a_i == SvcExit) begin
          res_o.sc_act   = ScExit;
          res_o.stop_now = 1'b1;
        end else if (op_a_i == SvcPrintChar) begin
          res_o.sc_act = ScPrintChar;
          res_o.sc_val = {{(DataWidth-8){1'b0}}, op_b_i[7:0]};
        end else begin
          res_o.sc_act   = ScUnknown;
          res_o.sc_val   = op_a_i;
          res_o.stop_now = 1'b1;
        end
      end
      OpNone: ;
      default: ;
    endcase
  end

endmodule
